// ===== sv/line_edit_buffer_top_assert.svh =====
// ---------------------------------------------------------------------------
// line edit buffer assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef LINE_EDIT_BUFFER_TOP_ASSERT_SVH
`define LINE_EDIT_BUFFER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LEB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line edit buffer: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LEB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line edit buffer: next-cycle check failed");

`endif

// ===== sv/leb_pkg.sv =====
// ---------------------------------------------------------------------------
// leb_pkg
// types and constants shared by the line edit buffer modules
// ---------------------------------------------------------------------------
package leb_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned CAP_W     = 7;
    localparam int unsigned REQ_W     = 3;
    // wide enough for any cell index up to 256 and for length plus headroom
    localparam int unsigned CMP_W     = 9;

    localparam int unsigned LEN_FIELD_LIMIT = 64;
    localparam int unsigned HEADROOM        = 2;
    localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;
    localparam logic [POS_W-1:0] MAX_LEN    = 6'd62;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT    = 3'd0,
        REQ_BACKSPACE = 3'd1,
        REQ_LEFT      = 3'd2,
        REQ_RIGHT     = 3'd3,
        REQ_CLEAR     = 3'd4,
        REQ_FINISH    = 3'd5,
        REQ_READ      = 3'd6
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              rot;
        logic [POS_W-1:0]  cursor;
        logic [CHAR_W-1:0] ch;
    } cell_cmd_t;

endpackage

// ===== sv/leb_cell.sv =====
// ---------------------------------------------------------------------------
// leb_cell
// one character slot of the line; takes from a neighbor on shift or rotate
// ---------------------------------------------------------------------------
module leb_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                             clk,
    input  leb_pkg::cell_cmd_t               cmd,
    input  logic [leb_pkg::CHAR_W-1:0]       lower_char,
    input  logic [leb_pkg::CHAR_W-1:0]       upper_char,
    output logic [leb_pkg::CHAR_W-1:0]       data_char
);

    localparam logic [leb_pkg::CMP_W-1:0] IDX_C = leb_pkg::CMP_W'(IDX);

    logic [leb_pkg::CHAR_W-1:0] data_reg;
    logic [leb_pkg::CHAR_W-1:0] data_next;
    logic [leb_pkg::CMP_W-1:0]  cur_ext;

    assign cur_ext = leb_pkg::CMP_W'(cmd.cursor);

    always_comb
    begin
        data_next = data_reg;
        priority if (cmd.rot)
        begin
            data_next = upper_char;
        end
        else if (cmd.ins)
        begin
            // tail moves up, the slot at the cursor takes the new character
            if (IDX_C > cur_ext)
            begin
                data_next = lower_char;
            end
            else if (IDX_C == cur_ext)
            begin
                data_next = cmd.ch;
            end
        end
        else if (cmd.del)
        begin
            // slots from cursor-1 upward take their upper neighbor
            if (IDX_C + leb_pkg::CMP_W'(1) >= cur_ext)
            begin
                data_next = upper_char;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_char = data_reg;

endmodule

// ===== sv/leb_ctrl.sv =====
// ---------------------------------------------------------------------------
// leb_ctrl
// request decode, length and cursor, capacity register and result registers
// ---------------------------------------------------------------------------
`include "line_edit_buffer_top_assert.svh"

module leb_ctrl #(
    parameter int unsigned DEPTH = leb_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [leb_pkg::REQ_W-1:0]     req_type,
    input  logic [leb_pkg::CHAR_W-1:0]    char_in,
    input  logic [leb_pkg::POS_W-1:0]     read_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [leb_pkg::CAP_W-1:0]     cfg_data,
    input  logic [leb_pkg::CHAR_W-1:0]    head_char,
    output leb_pkg::cell_cmd_t            cmd,
    output logic                          done,
    output logic                          status,
    output logic [leb_pkg::POS_W-1:0]     length,
    output logic [leb_pkg::POS_W-1:0]     cursor_pos,
    output logic [leb_pkg::CHAR_W-1:0]    read_char
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam int unsigned CAP_LIMIT =
        (DEPTH < leb_pkg::LEN_FIELD_LIMIT) ? DEPTH : leb_pkg::LEN_FIELD_LIMIT;
    localparam logic [leb_pkg::CMP_W-1:0] CAP_LIMIT_C = leb_pkg::CMP_W'(CAP_LIMIT);

    leb_pkg::state_t state_reg, state_next;
    logic [IW-1:0]                count_reg, count_next;
    logic [leb_pkg::POS_W-1:0]    len_reg, len_next;
    logic [leb_pkg::POS_W-1:0]    cur_reg, cur_next;
    logic [leb_pkg::CAP_W-1:0]    cap_reg;
    logic [leb_pkg::POS_W-1:0]    ridx_reg, ridx_next;
    logic                         done_reg, done_next;
    logic                         status_reg, status_next;
    logic [leb_pkg::POS_W-1:0]    olen_reg, olen_next;
    logic [leb_pkg::POS_W-1:0]    ocur_reg, ocur_next;
    logic [leb_pkg::CHAR_W-1:0]   rchar_reg, rchar_next;

    logic                         accept;
    leb_pkg::req_t                req;
    logic [leb_pkg::CMP_W-1:0]    cap_ext;
    logic [leb_pkg::CMP_W-1:0]    eff_cap;
    logic                         full;
    logic                         hit;

    assign accept  = start && (state_reg == leb_pkg::ST_IDLE);
    assign req     = leb_pkg::req_t'(req_type);
    assign cap_ext = leb_pkg::CMP_W'(cap_reg);
    assign eff_cap = (cap_ext < CAP_LIMIT_C) ? cap_ext : CAP_LIMIT_C;
    assign full    = (leb_pkg::CMP_W'(len_reg) + leb_pkg::CMP_W'(leb_pkg::HEADROOM))
                     >= eff_cap;
    // the head cell holds logical index count_reg during the read walk
    assign hit     = (leb_pkg::CMP_W'(count_reg) == leb_pkg::CMP_W'(ridx_reg))
                     && (ridx_reg < len_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            leb_pkg::ST_IDLE:
            begin
                if (accept && (req == leb_pkg::REQ_READ))
                begin
                    state_next = leb_pkg::ST_READ;
                    count_next = '0;
                end
            end
            leb_pkg::ST_READ:
            begin
                count_next = count_reg + IW'(1);
                if (count_reg == LAST)
                begin
                    state_next = leb_pkg::ST_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                state_next = leb_pkg::ST_IDLE;
            end
        endcase
    end

    // line state, cell commands and results
    always_comb
    begin
        len_next    = len_reg;
        cur_next    = cur_reg;
        ridx_next   = ridx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        olen_next   = olen_reg;
        ocur_next   = ocur_reg;
        rchar_next  = rchar_reg;
        cmd         = '{ins: 1'b0, del: 1'b0, rot: 1'b0, cursor: cur_reg, ch: char_in};
        unique case (state_reg)
            leb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = 1'b0;
                    rchar_next  = '0;
                    done_next   = 1'b1;
                    unique case (req)
                        leb_pkg::REQ_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                cmd.ins  = 1'b1;
                                cur_next = cur_reg + leb_pkg::POS_W'(1);
                                len_next = len_reg + leb_pkg::POS_W'(1);
                            end
                        end
                        leb_pkg::REQ_BACKSPACE:
                        begin
                            if (cur_reg != '0)
                            begin
                                cmd.del  = 1'b1;
                                cur_next = cur_reg - leb_pkg::POS_W'(1);
                                len_next = len_reg - leb_pkg::POS_W'(1);
                            end
                        end
                        leb_pkg::REQ_LEFT:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next = cur_reg - leb_pkg::POS_W'(1);
                            end
                        end
                        leb_pkg::REQ_RIGHT:
                        begin
                            if (cur_reg < len_reg)
                            begin
                                cur_next = cur_reg + leb_pkg::POS_W'(1);
                            end
                        end
                        leb_pkg::REQ_CLEAR,
                        leb_pkg::REQ_FINISH:
                        begin
                            cur_next = '0;
                            len_next = '0;
                        end
                        leb_pkg::REQ_READ:
                        begin
                            done_next = 1'b0;
                            ridx_next = read_index;
                        end
                        default:
                        begin
                        end
                    endcase
                    // finish reports the length it had before emptying
                    olen_next = (req == leb_pkg::REQ_FINISH) ? len_reg : len_next;
                    ocur_next = cur_next;
                end
            end
            leb_pkg::ST_READ:
            begin
                cmd.rot = 1'b1;
                if (hit)
                begin
                    rchar_next = head_char;
                end
                done_next = (count_reg == LAST);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= leb_pkg::ST_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            cur_reg   <= '0;
            cap_reg   <= leb_pkg::CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            done_reg  <= done_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg   <= ridx_next;
        status_reg <= status_next;
        olen_reg   <= olen_next;
        ocur_reg   <= ocur_next;
        rchar_reg  <= rchar_next;
    end

    assign busy       = (state_reg == leb_pkg::ST_READ);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign status     = status_reg;
    assign length     = olen_reg;
    assign cursor_pos = ocur_reg;
    assign read_char  = rchar_reg;

    `LEB_ASSERT_SAME(a_cursor_in_line, 1'b1, (cur_reg <= len_reg) && (len_reg <= leb_pkg::MAX_LEN))
    `LEB_ASSERT_SAME(a_no_result_in_walk, state_reg == leb_pkg::ST_READ, !done_reg)
    `LEB_ASSERT_NEXT(a_edit_result, accept && (req != leb_pkg::REQ_READ), done_reg && !busy)
    `LEB_ASSERT_NEXT(a_read_result, busy && (count_reg == LAST), done_reg && !busy)

endmodule

// ===== sv/line_edit_buffer_top.sv =====
// ---------------------------------------------------------------------------
// line_edit_buffer_top
// keyboard line-edit store: character row, length, cursor and capacity
// ---------------------------------------------------------------------------
// Results cannot be stalled: each one shows on status, length, cursor_pos and
// read_char for exactly one cycle with done high, and must be taken then.
// Insert, backspace, cursor moves, clear and finish are accepted whenever busy
// is low and give their result in the next cycle; busy stays low, so one such
// request per cycle is taken. A read request rotates the ring of DEPTH
// character cells once around to bring the wanted slot to the head cell:
// busy is high for the whole walk and the result follows after it. The
// capacity register may be written when nothing is in flight; cfg_ready is
// always high.
module line_edit_buffer_top #(
    parameter int unsigned DEPTH = leb_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [leb_pkg::REQ_W-1:0]     req_type,
    input  logic [leb_pkg::CHAR_W-1:0]    char_in,
    input  logic [leb_pkg::POS_W-1:0]     read_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [leb_pkg::CAP_W-1:0]     cfg_data,
    output logic                          done,
    output logic                          status,
    output logic [leb_pkg::POS_W-1:0]     length,
    output logic [leb_pkg::POS_W-1:0]     cursor_pos,
    output logic [leb_pkg::CHAR_W-1:0]    read_char
);

    leb_pkg::cell_cmd_t         cmd;
    logic [leb_pkg::CHAR_W-1:0] cell_q [DEPTH];

    leb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .char_in    (char_in),
        .read_index (read_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .head_char  (cell_q[0]),
        .cmd        (cmd),
        .done       (done),
        .status     (status),
        .length     (length),
        .cursor_pos (cursor_pos),
        .read_char  (read_char)
    );

    // cells form a ring so the read walk ends where it started
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        leb_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .lower_char (cell_q[(i + DEPTH - 1) % DEPTH]),
            .upper_char (cell_q[(i + 1) % DEPTH]),
            .data_char  (cell_q[i])
        );
    end

endmodule

// ===== test/tb_line_edit_buffer_top.sv =====
// ---------------------------------------------------------------------------
// tb_line_edit_buffer_top
// self-checking bench: edit requests against an in-bench line model, with
// directed edge cases, capacity extremes and long random edit sessions
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_line_edit_buffer_top;

    localparam int unsigned DEPTH        = leb_pkg::DEPTH_DEF;
    localparam logic [leb_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int unsigned MAX_CYCLES   = 400000;
    localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
    localparam int unsigned RANDOM_ITEMS = 550;
    localparam int unsigned PHASE_ITEMS  = 50;

    typedef struct packed {
        logic                       status;
        logic [leb_pkg::POS_W-1:0]  length;
        logic [leb_pkg::POS_W-1:0]  cursor;
        logic [leb_pkg::CHAR_W-1:0] rchar;
    } edit_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [leb_pkg::REQ_W-1:0]  req_type;
    logic [leb_pkg::CHAR_W-1:0] char_in;
    logic [leb_pkg::POS_W-1:0]  read_index;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [leb_pkg::CAP_W-1:0]  cfg_data;
    logic                       done;
    logic                       status;
    logic [leb_pkg::POS_W-1:0]  length;
    logic [leb_pkg::POS_W-1:0]  cursor_pos;
    logic [leb_pkg::CHAR_W-1:0] read_char;

    // line model
    logic [leb_pkg::CHAR_W-1:0] line_chars [DEPTH];
    int unsigned       line_len;
    int unsigned       edit_pos;
    int unsigned       cap_reg;

    edit_result_t      expected_results [$];

    int unsigned err_count;
    int unsigned cycle_count;
    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_reads;
    int unsigned n_refused;
    int unsigned n_cap_writes;

    line_edit_buffer_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .char_in   (char_in),
        .read_index(read_index),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .status    (status),
        .length    (length),
        .cursor_pos(cursor_pos),
        .read_char (read_char)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // applies one request to the line model and returns what the block reports
    function automatic edit_result_t predict_edit(input logic [leb_pkg::REQ_W-1:0] req,
                                                  input logic [leb_pkg::CHAR_W-1:0] ch,
                                                  input logic [leb_pkg::POS_W-1:0] idx);
        edit_result_t res;
        int unsigned  eff_cap;
        int unsigned  i;
        res = '0;
        eff_cap = cap_reg;
        if (eff_cap > DEPTH)
            eff_cap = DEPTH;
        if (eff_cap > leb_pkg::LEN_FIELD_LIMIT)
            eff_cap = leb_pkg::LEN_FIELD_LIMIT;
        case (req)
            leb_pkg::REQ_INSERT:
            begin
                if (line_len + leb_pkg::HEADROOM >= eff_cap)
                    res.status = 1'b1;
                else
                begin
                    for (i = line_len; i > edit_pos; i--)
                        if (i < DEPTH)
                            line_chars[i] = line_chars[i-1];
                    if (edit_pos < DEPTH)
                        line_chars[edit_pos] = ch;
                    edit_pos++;
                    line_len++;
                end
            end
            leb_pkg::REQ_BACKSPACE:
            begin
                if (edit_pos > 0)
                begin
                    for (i = edit_pos - 1; i + 1 < line_len; i++)
                        if (i + 1 < DEPTH)
                            line_chars[i] = line_chars[i+1];
                    edit_pos--;
                    line_len--;
                end
            end
            leb_pkg::REQ_LEFT:
                if (edit_pos > 0)
                    edit_pos--;
            leb_pkg::REQ_RIGHT:
                if (edit_pos < line_len)
                    edit_pos++;
            leb_pkg::REQ_CLEAR:
            begin
                line_len = 0;
                edit_pos = 0;
            end
            leb_pkg::REQ_READ:
                if (idx < line_len && idx < DEPTH)
                    res.rchar = line_chars[idx];
            default:
                ;
        endcase
        res.length = line_len[leb_pkg::POS_W-1:0];
        // finish reports the completed length, then empties the line
        if (req == leb_pkg::REQ_FINISH)
        begin
            line_len = 0;
            edit_pos = 0;
        end
        res.cursor = edit_pos[leb_pkg::POS_W-1:0];
        return res;
    endfunction

    task automatic issue_edit(input logic [leb_pkg::REQ_W-1:0] req,
                              input logic [leb_pkg::CHAR_W-1:0] ch,
                              input logic [leb_pkg::POS_W-1:0] idx);
        edit_result_t res;
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= req;
        char_in    <= ch;
        read_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = predict_edit(req, ch, idx);
        expected_results.push_back(res);
        n_sent++;
        if (req == leb_pkg::REQ_READ)
            n_reads++;
        if (res.status)
            n_refused++;
    endtask

    task automatic pause(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_idle();
        pause(1);
        do
            @(posedge clk);
        while (expected_results.size() != 0 || busy);
    endtask

    task automatic write_capacity(input logic [leb_pkg::CAP_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_reg = value;
        n_cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker: every done pulse must match the oldest expectation
    always @(posedge clk)
    begin : result_check
        edit_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing pending: status %0d length %0d cursor %0d",
                       status, length, cursor_pos);
                err_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    err_count++;
                end
                if (length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, length);
                    err_count++;
                end
                if (cursor_pos !== want.cursor)
                begin
                    $error("cursor_pos: expected %0d, got %0d", want.cursor, cursor_pos);
                    err_count++;
                end
                if (read_char !== want.rchar)
                begin
                    $error("read_char: expected 0x%02h, got 0x%02h", want.rchar, read_char);
                    err_count++;
                end
            end
        end
    end

    task automatic test_directed();
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd0);          // read on an empty line
        issue_edit(leb_pkg::REQ_READ, 8'hFF, 6'd63);
        issue_edit(leb_pkg::REQ_INSERT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'hFF, 6'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'hA5, 6'd0);
        issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'h5A, 6'd0);        // insert in the middle
        issue_edit(leb_pkg::REQ_RIGHT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_RIGHT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_RIGHT, 8'h00, 6'd0);         // already at the end
        issue_edit(leb_pkg::REQ_BACKSPACE, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);          // already at zero
        issue_edit(leb_pkg::REQ_BACKSPACE, 8'h00, 6'd0);     // nothing before the cursor
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd1);
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd3);          // at the length
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd63);
        issue_edit(REQ_UNUSED, 8'hFF, 6'd63);
        issue_edit(leb_pkg::REQ_FINISH, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'h41, 6'd0);
        issue_edit(leb_pkg::REQ_CLEAR, 8'h00, 6'd0);
    endtask

    task automatic test_capacity_extremes();
        int unsigned k;
        write_capacity(7'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'h31, 6'd0);
        issue_edit(leb_pkg::REQ_RIGHT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd0);
        write_capacity(7'd1);
        issue_edit(leb_pkg::REQ_INSERT, 8'h32, 6'd0);
        write_capacity(7'd2);
        issue_edit(leb_pkg::REQ_INSERT, 8'h33, 6'd0);
        write_capacity(7'd3);
        issue_edit(leb_pkg::REQ_INSERT, 8'h34, 6'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'h35, 6'd0);
        issue_edit(leb_pkg::REQ_FINISH, 8'h00, 6'd0);
        // above the store size: the line tops out at 62
        write_capacity(7'd127);
        for (k = 0; k < 63; k++)
        begin
            if (k % 9 == 4)
                issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);
            issue_edit(leb_pkg::REQ_INSERT, leb_pkg::CHAR_W'($urandom_range(0, 255)), 6'd0);
        end
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd61);
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd62);
        issue_edit(leb_pkg::REQ_BACKSPACE, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'h7E, 6'd0);
        issue_edit(leb_pkg::REQ_INSERT, 8'h7F, 6'd0);
        // shrink under the long line: it stays, inserts are refused
        write_capacity(7'd10);
        issue_edit(leb_pkg::REQ_INSERT, 8'h20, 6'd0);
        issue_edit(leb_pkg::REQ_LEFT, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_BACKSPACE, 8'h00, 6'd0);
        issue_edit(leb_pkg::REQ_READ, 8'h00, 6'd30);
        issue_edit(leb_pkg::REQ_RIGHT, 8'h00, 6'd0);
        write_capacity(7'd64);
        issue_edit(leb_pkg::REQ_FINISH, 8'h00, 6'd0);
    endtask

    function automatic logic [leb_pkg::REQ_W-1:0] REQ_TYPE_RANDOM();
        return leb_pkg::REQ_W'($urandom_range(0, 7));
    endfunction

    task automatic test_random_sessions();
        int unsigned n;
        int unsigned r;
        logic [leb_pkg::REQ_W-1:0]  req;
        logic [leb_pkg::POS_W-1:0]  idx;
        logic                       gaps_on;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            // mostly small capacities so the full case shows up often
            if ($urandom_range(0, 3) == 0)
                write_capacity(leb_pkg::CAP_W'($urandom_range(0, 127)));
            else
                write_capacity(leb_pkg::CAP_W'($urandom_range(2, 20)));
            // no gaps in the last stretch of the run
            gaps_on = (n + 2 * PHASE_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    req = leb_pkg::REQ_INSERT;
                else if (r < 55)
                    req = leb_pkg::REQ_BACKSPACE;
                else if (r < 63)
                    req = leb_pkg::REQ_LEFT;
                else if (r < 71)
                    req = leb_pkg::REQ_RIGHT;
                else if (r < 86)
                    req = leb_pkg::REQ_READ;
                else if (r < 89)
                    req = leb_pkg::REQ_CLEAR;
                else if (r < 94)
                    req = leb_pkg::REQ_FINISH;
                else if (r < 97)
                    req = REQ_UNUSED;
                else
                    req = REQ_TYPE_RANDOM();
                if (line_len > 0 && $urandom_range(0, 4) != 0)
                    idx = leb_pkg::POS_W'($urandom_range(0, line_len));
                else
                    idx = leb_pkg::POS_W'($urandom_range(0, 63));
                if (gaps_on && $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 14));
                issue_edit(req, leb_pkg::CHAR_W'($urandom_range(0, 255)), idx);
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = leb_pkg::REQ_INSERT;
        char_in      = '0;
        read_index   = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        err_count    = 0;
        cycle_count  = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_reads      = 0;
        n_refused    = 0;
        n_cap_writes = 0;
        line_len     = 0;
        edit_pos     = 0;
        cap_reg      = leb_pkg::CAP_RESET;
        foreach (line_chars[i])
            line_chars[i] = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_capacity_extremes();
        test_random_sessions();

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("covered %0d requests: %0d reads, %0d refused inserts, %0d capacity writes",
                 n_sent, n_reads, n_refused, n_cap_writes);
        $display("compared %0d results in %0d cycles", n_checked, cycle_count);
        if (err_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/leb_pkg.sv
sv/leb_cell.sv
sv/leb_ctrl.sv
sv/line_edit_buffer_top.sv
test/tb_line_edit_buffer_top.sv
